FILE: rtl/cbtq_pkg.sv
// shared types and constants for the coalescing blocked task queue
`timescale 1ns / 1ps
package cbtq_pkg;
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] POL_HOT = 2'd1;
  localparam logic [1:0] POL_DISCARD = 2'd2;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_COALESCED = 3'd1;
  localparam logic [2:0] ST_DROPPED = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_WOKEN = 3'd4;
  localparam logic [2:0] ST_NONE = 3'd5;

  typedef struct packed {
    logic [31:0] key;
    logic [1:0]  policy;
    logic [7:0]  reason;
    logic [2:0]  wake;
    logic [31:0] eligible;
    logic [31:0] revision;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic        write;    // load this cell's slot from the new record
    logic        shift;    // take the upper neighbour's entry (close up)
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] sh_idx; // cells at or above this index take the neighbour
  } cell_ctl_t;
endpackage

FILE: rtl/cbtq_cell.sv
// one queue slot: holds an entry and can take its upper neighbour's entry
`timescale 1ns / 1ps
module cbtq_cell (
  input  logic                 clk,
  input  logic [cbtq_pkg::IDX_W-1:0] my_idx,
  input  cbtq_pkg::cell_ctl_t  ctl,
  input  cbtq_pkg::entry_t     new_entry,
  input  cbtq_pkg::entry_t     upper,
  output cbtq_pkg::entry_t     entry
);
  cbtq_pkg::entry_t entry_r;
  assign entry = entry_r;

  always_ff @(posedge clk) begin
    if (ctl.write && ctl.wr_idx == my_idx) begin
      entry_r <= new_entry;
    end else if (ctl.shift && my_idx >= ctl.sh_idx) begin
      entry_r <= upper;
    end
  end
endmodule

FILE: rtl/coalescing_blocked_task_queue_core.sv
// top level: coalescing blocked task queue on a row of shifting cells
//
//  channel | direction | handshake      | payload
//  in_     | input     | valid / stall  | kind, record fields, wake revisions
//  out_    | output    | valid / stall  | status, woken record, last, occupancy
//  cfg_    | input     | valid / ready  | capacity (5 bits)
//
// a push checks one cell a cycle: first the key search over the held cells (the final
// step appends), then the discardable search when the queue is full, then the result
// beat is loaded.
// a wake checks one cell a cycle while the output is free; a due cell is held back so
// that the final beat can carry last, and the row closes up behind it in the same cycle.
// reset empties the queue and sets capacity to DEPTH; no clearing pass.
// a stalled output beat holds the sequencer; input is taken only when idle, with
// no beat waiting and no configuration write offered.
`timescale 1ns / 1ps
module coalescing_blocked_task_queue_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [31:0] in_signature,
  input  logic [1:0]  in_retention,
  input  logic [7:0]  in_blocking_reason,
  input  logic [2:0]  in_wake_kind,
  input  logic [31:0] in_next_eligible_loop,
  input  logic [31:0] in_seen_revision,
  input  logic [31:0] in_current_loop,
  input  logic [31:0] in_producer_revision,
  input  logic [31:0] in_resource_revision,
  input  logic [31:0] in_placement_revision,
  input  logic [31:0] in_goal_revision,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_signature,
  output logic [1:0]  out_retention,
  output logic [7:0]  out_reason,
  output logic [2:0]  out_wake_kind,
  output logic [31:0] out_next_loop,
  output logic [31:0] out_seen_revision,
  output logic        out_last,
  output logic [4:0]  out_occupancy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_capacity
);
  localparam int DEPTH = cbtq_pkg::DEPTH;
  localparam int CW = cbtq_pkg::CNT_W;
  localparam int IW = cbtq_pkg::IDX_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KEY  = 3'd1;
  localparam logic [2:0] S_DISC = 3'd2;
  localparam logic [2:0] S_WAKE = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [CW-1:0] held_r, held_nxt, cap_r, cap_nxt, ptr_r, ptr_nxt;
  logic        woke_r, woke_nxt;
  cbtq_pkg::entry_t rec_r;
  logic [31:0] now_r, prod_r, res_r, plc_r, goal_r;

  // woken beat held back until the next due cell or the end of the scan
  cbtq_pkg::entry_t hent_r, hent_nxt;
  logic [CW-1:0] hocc_r, hocc_nxt;

  // output register
  logic        ov_r, ov_nxt;
  logic [2:0]  ost_r, ost_nxt;
  cbtq_pkg::entry_t oent_r, oent_nxt;
  logic        olast_r, olast_nxt;
  logic [CW-1:0] oocc_r, oocc_nxt;

  cbtq_pkg::cell_ctl_t ctl;
  cbtq_pkg::entry_t ent [DEPTH];
  cbtq_pkg::entry_t cur;
  logic [IW-1:0] pidx;
  logic due;
  logic [31:0] rev_sel;

  // row of cells; the top cell takes its own value on a shift
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cbtq_cell u_cell (
      .clk       (clk),
      .my_idx    (IW'(g)),
      .ctl       (ctl),
      .new_entry (rec_r),
      .upper     (ent[(g + 1 < DEPTH) ? g + 1 : g]),
      .entry     (ent[g])
    );
  end

  assign pidx = ptr_r[IW-1:0];
  assign cur = ent[pidx];

  always_comb begin
    unique case (cur.wake)
      3'd1: rev_sel = prod_r;
      3'd2: rev_sel = res_r;
      3'd3: rev_sel = plc_r;
      3'd4: rev_sel = goal_r;
      default: rev_sel = cur.revision;
    endcase
    due = (now_r >= cur.eligible) || (rev_sel != cur.revision);
  end

  // sequencer stalls while a beat waits
  logic ofree;
  assign ofree = !ov_r || !out_stall;

  // an offered configuration write goes first, so input waits for it
  assign in_stall = (state_r != S_IDLE) || ov_r || cfg_valid;
  assign cfg_ready = (state_r == S_IDLE) && !ov_r;

  always_comb begin
    state_nxt = state_r; held_nxt = held_r; cap_nxt = cap_r; ptr_nxt = ptr_r;
    woke_nxt = woke_r; hent_nxt = hent_r; hocc_nxt = hocc_r;
    ov_nxt = ov_r && out_stall; ost_nxt = ost_r; oent_nxt = oent_r;
    olast_nxt = olast_r; oocc_nxt = oocc_r;
    ctl = '0;
    ctl.wr_idx = pidx;
    ctl.sh_idx = pidx;

    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid && cfg_ready) begin
          cap_nxt = (cfg_capacity > 5'(DEPTH)) ? CW'(DEPTH) : CW'(cfg_capacity);
          held_nxt = '0;
        end else if (in_valid && !in_stall) begin
          ptr_nxt = '0;
          woke_nxt = 1'b0;
          state_nxt = in_kind ? S_WAKE : S_KEY;
        end
      end
      S_KEY: begin
        if (cap_r == '0) begin
          ost_nxt = (rec_r.policy == cbtq_pkg::POL_HOT) ?
                    cbtq_pkg::ST_REJECTED : cbtq_pkg::ST_DROPPED;
          state_nxt = S_OUT;
        end else if (ptr_r < held_r) begin
          if (cur.key == rec_r.key) begin
            ctl.write = 1'b1;
            ost_nxt = cbtq_pkg::ST_COALESCED;
            state_nxt = S_OUT;
          end else begin
            ptr_nxt = ptr_r + 1'b1;
          end
        end else if (held_r < cap_r) begin
          ctl.write = 1'b1;
          ctl.wr_idx = held_r[IW-1:0];
          held_nxt = held_r + 1'b1;
          ost_nxt = cbtq_pkg::ST_ACCEPTED;
          state_nxt = S_OUT;
        end else begin
          ptr_nxt = '0;
          state_nxt = S_DISC;
        end
      end
      S_DISC: begin
        if (ptr_r < held_r) begin
          if (cur.policy == cbtq_pkg::POL_DISCARD) begin
            // close up and append at the top slot
            ctl.shift = 1'b1;
            ctl.write = 1'b1;
            ctl.wr_idx = IW'(held_r - 1'b1);
            ost_nxt = cbtq_pkg::ST_ACCEPTED;
            state_nxt = S_OUT;
          end else begin
            ptr_nxt = ptr_r + 1'b1;
          end
        end else begin
          ost_nxt = (rec_r.policy == cbtq_pkg::POL_HOT) ?
                    cbtq_pkg::ST_REJECTED : cbtq_pkg::ST_DROPPED;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (ofree) begin
          ov_nxt = 1'b1; oent_nxt = '0; olast_nxt = 1'b1; oocc_nxt = held_r;
          state_nxt = S_IDLE;
        end
      end
      S_WAKE: begin
        if (ofree) begin
          if (ptr_r < held_r) begin
            if (due) begin
              ctl.shift = 1'b1;
              held_nxt = held_r - 1'b1;
              hent_nxt = cur;
              hocc_nxt = held_r - 1'b1;
              woke_nxt = 1'b1;
              // a later due cell means the held beat is not the final one
              if (woke_r) begin
                ov_nxt = 1'b1; ost_nxt = cbtq_pkg::ST_WOKEN; oent_nxt = hent_r;
                olast_nxt = 1'b0; oocc_nxt = hocc_r;
              end
            end else begin
              ptr_nxt = ptr_r + 1'b1;
            end
          end else if (woke_r) begin
            // scan over: the held beat is the final one
            ov_nxt = 1'b1; ost_nxt = cbtq_pkg::ST_WOKEN; oent_nxt = hent_r;
            olast_nxt = 1'b1; oocc_nxt = hocc_r;
            woke_nxt = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            ov_nxt = 1'b1; ost_nxt = cbtq_pkg::ST_NONE; oent_nxt = '0;
            olast_nxt = 1'b1; oocc_nxt = held_r;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; held_r <= '0; cap_r <= CW'(DEPTH); ptr_r <= '0;
      woke_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; held_r <= held_nxt; cap_r <= cap_nxt; ptr_r <= ptr_nxt;
      woke_r <= woke_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ost_r <= ost_nxt; oent_r <= oent_nxt; olast_r <= olast_nxt; oocc_r <= oocc_nxt;
    hent_r <= hent_nxt; hocc_r <= hocc_nxt;
    if (state_r == S_IDLE && in_valid && !in_stall) begin
      rec_r.key <= in_signature;
      rec_r.policy <= in_retention;
      rec_r.reason <= in_blocking_reason;
      rec_r.wake <= in_wake_kind;
      rec_r.eligible <= in_next_eligible_loop;
      rec_r.revision <= in_seen_revision;
      now_r <= in_current_loop;
      prod_r <= in_producer_revision;
      res_r <= in_resource_revision;
      plc_r <= in_placement_revision;
      goal_r <= in_goal_revision;
    end
  end

  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_signature = oent_r.key;
  assign out_retention = oent_r.policy;
  assign out_reason = oent_r.reason;
  assign out_wake_kind = oent_r.wake;
  assign out_next_loop = oent_r.eligible;
  assign out_seen_revision = oent_r.revision;
  assign out_last = olast_r;
  assign out_occupancy = 5'(oocc_r);
endmodule

FILE: tb/sv/tb.sv
// testbench for the coalescing blocked task queue: directed and random pushes and wakes
`timescale 1ns / 1ps
module tb;
  typedef struct {
    logic        kind;
    logic [31:0] sig;
    logic [1:0]  ret;
    logic [7:0]  reason;
    logic [2:0]  wk;
    logic [31:0] nel;
    logic [31:0] seen;
    logic [31:0] cur;
    logic [31:0] prod;
    logic [31:0] res;
    logic [31:0] plc;
    logic [31:0] goal;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    cbtq_pkg::entry_t  rec;
    logic              last;
    logic [4:0]        occ;
  } beat_t;

  localparam int WATCHDOG = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [31:0] in_signature;
  logic [1:0]  in_retention;
  logic [7:0]  in_blocking_reason;
  logic [2:0]  in_wake_kind;
  logic [31:0] in_next_eligible_loop;
  logic [31:0] in_seen_revision;
  logic [31:0] in_current_loop;
  logic [31:0] in_producer_revision;
  logic [31:0] in_resource_revision;
  logic [31:0] in_placement_revision;
  logic [31:0] in_goal_revision;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [31:0] out_signature;
  logic [1:0]  out_retention;
  logic [7:0]  out_reason;
  logic [2:0]  out_wake_kind;
  logic [31:0] out_next_loop;
  logic [31:0] out_seen_revision;
  logic        out_last;
  logic [4:0]  out_occupancy;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_capacity;

  coalescing_blocked_task_queue_core u_top (.*);

  // predictor state
  cbtq_pkg::entry_t q_rows[$];
  int unsigned q_cap;
  beat_t       pending[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          calm;     // no idling on either side while set
  bit          finished;
  logic [31:0] keys[8];  // small key pool so coalescing happens often

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // watchdog: cycles with nothing accepted on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG && !finished) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(99) < 8);
  end

  function automatic void add_row(cbtq_pkg::entry_t e);
    q_rows.insert(q_rows.size(), e);
  endfunction

  function automatic void add_beat(beat_t b);
    pending.insert(pending.size(), b);
  endfunction

  function automatic bit row_due(cbtq_pkg::entry_t e, req_t r);
    logic [31:0] now_rev;
    if (r.cur >= e.eligible) return 1;
    case (e.wake)
      3'd1: now_rev = r.prod;
      3'd2: now_rev = r.res;
      3'd3: now_rev = r.plc;
      3'd4: now_rev = r.goal;
      default: now_rev = e.revision;
    endcase
    return now_rev != e.revision;
  endfunction

  // expected beats for one accepted request
  task automatic queue_outcome(req_t r);
    beat_t  b;
    cbtq_pkg::entry_t e;
    int     i;
    bit     done;
    int     n;
    b = '0;
    if (!r.kind) begin
      e = '{key: r.sig, policy: r.ret, reason: r.reason, wake: r.wk,
            eligible: r.nel, revision: r.seen};
      done = 0;
      if (q_cap != 0) begin
        for (i = 0; i < q_rows.size(); i++)
          if (!done && q_rows[i].key == r.sig) begin
            q_rows[i] = e; b.status = cbtq_pkg::ST_COALESCED; done = 1;
          end
        if (!done && q_rows.size() < q_cap) begin
          add_row(e); b.status = cbtq_pkg::ST_ACCEPTED; done = 1;
        end
        for (i = 0; i < q_rows.size(); i++)
          if (!done && q_rows[i].policy == cbtq_pkg::POL_DISCARD) begin
            q_rows.delete(i); add_row(e); b.status = cbtq_pkg::ST_ACCEPTED; done = 1;
          end
      end
      if (!done)
        b.status = (r.ret == cbtq_pkg::POL_HOT) ? cbtq_pkg::ST_REJECTED :
                                                  cbtq_pkg::ST_DROPPED;
      b.last = 1;
      b.occ = 5'(q_rows.size());
      add_beat(b);
    end else begin
      n = 0;
      i = 0;
      while (i < q_rows.size()) begin
        if (!row_due(q_rows[i], r)) begin
          i++;
        end else begin
          b = '0;
          b.status = cbtq_pkg::ST_WOKEN;
          b.rec = q_rows[i];
          q_rows.delete(i);
          b.occ = 5'(q_rows.size());
          add_beat(b);
          n++;
        end
      end
      if (n == 0) begin
        b = '0;
        b.status = cbtq_pkg::ST_NONE;
        b.last = 1;
        b.occ = 5'(q_rows.size());
        add_beat(b);
      end else begin
        b = pending.pop_back();
        b.last = 1;
        add_beat(b);
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    beat_t x;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        x = pending.pop_front();
        if (out_status !== x.status) begin
          $error("status exp %0d got %0d", x.status, out_status); errors++;
        end
        if (out_signature !== x.rec.key) begin
          $error("out_signature exp %h got %h", x.rec.key, out_signature); errors++;
        end
        if (out_retention !== x.rec.policy) begin
          $error("out_retention exp %0d got %0d", x.rec.policy, out_retention); errors++;
        end
        if (out_reason !== x.rec.reason) begin
          $error("out_reason exp %0d got %0d", x.rec.reason, out_reason); errors++;
        end
        if (out_wake_kind !== x.rec.wake) begin
          $error("out_wake_kind exp %0d got %0d", x.rec.wake, out_wake_kind); errors++;
        end
        if (out_next_loop !== x.rec.eligible) begin
          $error("out_next_loop exp %h got %h", x.rec.eligible, out_next_loop); errors++;
        end
        if (out_seen_revision !== x.rec.revision) begin
          $error("out_seen_revision exp %h got %h", x.rec.revision, out_seen_revision);
          errors++;
        end
        if (out_last !== x.last) begin
          $error("last exp %0d got %0d", x.last, out_last); errors++;
        end
        if (out_occupancy !== x.occ) begin
          $error("occupancy exp %0d got %0d", x.occ, out_occupancy); errors++;
        end
      end
    end
  end

  // one input beat, held until taken; entered and left at a falling edge
  task automatic send_req(req_t r);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 8) @(negedge clk);
    in_valid <= 1'b1;
    in_kind <= r.kind;
    in_signature <= r.sig;
    in_retention <= r.ret;
    in_blocking_reason <= r.reason;
    in_wake_kind <= r.wk;
    in_next_eligible_loop <= r.nel;
    in_seen_revision <= r.seen;
    in_current_loop <= r.cur;
    in_producer_revision <= r.prod;
    in_resource_revision <= r.res;
    in_placement_revision <= r.plc;
    in_goal_revision <= r.goal;
    // stall only moves after a rising edge, so it is read at the falling edge
    while (in_stall) @(negedge clk);
    @(posedge clk);
    queue_outcome(r);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_wait();
    while (pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_capacity(logic [4:0] v);
    drain_wait();
    cfg_valid <= 1'b1;
    cfg_capacity <= v;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    q_cap = (v > cbtq_pkg::DEPTH) ? cbtq_pkg::DEPTH : v;
    q_rows.delete();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t make_push(logic [31:0] k, logic [1:0] p, logic [31:0] nel,
                                     logic [2:0] w);
    req_t r;
    r = '{default: '0};
    r.sig = k; r.ret = p; r.nel = nel; r.wk = w;
    r.reason = 8'($urandom); r.seen = $urandom_range(3);
    return r;
  endfunction

  function automatic req_t make_wake(logic [31:0] now);
    req_t r;
    r = '{default: '0};
    r.kind = 1; r.cur = now;
    r.prod = $urandom_range(3); r.res = $urandom_range(3);
    r.plc = $urandom_range(3); r.goal = $urandom_range(3);
    r.sig = $urandom; r.ret = 2'($urandom); r.reason = 8'($urandom);
    r.wk = 3'($urandom);
    r.nel = $urandom; r.seen = $urandom;
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int   pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      r = make_push(keys[$urandom_range(7)], 2'($urandom),
                    $urandom_range(3) == 0 ? $urandom : $urandom_range(400),
                    3'($urandom));
      if ($urandom_range(9) == 0) r.sig = $urandom;
      if ($urandom_range(9) == 0) r.seen = $urandom;
      r.cur = $urandom; r.prod = $urandom; r.goal = $urandom;
    end else if (pick < 95) begin
      r = make_wake($urandom_range(300));
    end else begin
      r = make_wake($urandom);
      r.prod = $urandom; r.res = $urandom; r.plc = $urandom; r.goal = $urandom;
    end
    return r;
  endfunction

  // extremes of the record fields, coalescing and a wake that finds nothing
  task automatic test_field_extremes();
    req_t r;
    r = make_push(32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF, 3'd7);
    r.reason = 8'hFF; r.seen = 32'hFFFF_FFFF;
    r.cur = '1; r.prod = '1; r.res = '1; r.plc = '1; r.goal = '1;
    send_req(r);
    send_req(make_push(32'h0, 2'd0, 32'h0, 3'd0));
    send_req(make_push(32'hFFFF_FFFF, cbtq_pkg::POL_HOT, 32'hFFFF_FFFE, 3'd5)); // coalesce
    r = make_wake(32'hFFFF_FFFF);
    r.prod = '1; r.res = '1; r.plc = '1; r.goal = '1;
    send_req(r);
    send_req(make_wake(32'h0)); // empty queue, none woken
  endtask

  // revision-driven wakes for each wake kind, cooldown-only kinds ignore revisions
  task automatic test_wake_kinds();
    req_t r;
    for (int w = 0; w < 8; w++)
      send_req(make_push(100 + w, 2'd0, 32'hFFFF_FFF0, 3'(w)));
    r = make_wake(32'd5);
    r.prod = 32'hA; r.res = 32'hA; r.plc = 32'hA; r.goal = 32'hA;
    send_req(r);
    send_req(make_wake(32'hFFFF_FFFF));
  endtask

  // full queue: eviction of the oldest discardable entry, then drop and reject
  task automatic test_full_queue();
    set_capacity(5'd2);
    send_req(make_push(1, 2'd0, 0, 0));
    send_req(make_push(2, cbtq_pkg::POL_DISCARD, 0, 0));
    send_req(make_push(3, cbtq_pkg::POL_HOT, 0, 0)); // evicts key 2
    send_req(make_push(4, cbtq_pkg::POL_HOT, 0, 0)); // rejected
    send_req(make_push(5, 2'd0, 0, 0));              // dropped
    send_req(make_wake(32'd0));
  endtask

  // capacity zero and oversized settings
  task automatic test_capacity_limits();
    set_capacity(5'd0);
    send_req(make_push(9, cbtq_pkg::POL_HOT, 0, 0));
    send_req(make_push(9, 2'd0, 0, 0));
    send_req(make_wake(32'd0));
    set_capacity(5'd31);
    for (int k = 0; k < 17; k++) send_req(make_push(200 + k, 2'd0, 50, 0));
    send_req(make_wake(32'd60));
  endtask

  // random mix over several capacities, with a calm stretch in the fourth phase
  task automatic test_random_mix();
    logic [4:0] caps[5] = '{5'd16, 5'd1, 5'd4, 5'd9, 5'd16};
    for (int ph = 0; ph < 5; ph++) begin
      set_capacity(caps[ph]);
      for (int k = 0; k < 8; k++) keys[k] = (ph == 2) ? k : $urandom;
      calm = (ph == 3);
      for (int n = 0; n < 92; n++) send_req(rand_req());
      calm = 0;
    end
  endtask

  initial begin
    calm = 0;
    finished = 0;
    q_cap = cbtq_pkg::DEPTH;
    rst_n = 0;
    in_valid = 0;
    in_kind = 0;
    in_signature = 0;
    in_retention = 0;
    in_blocking_reason = 0;
    in_wake_kind = 0;
    in_next_eligible_loop = 0;
    in_seen_revision = 0;
    in_current_loop = 0;
    in_producer_revision = 0;
    in_resource_revision = 0;
    in_placement_revision = 0;
    in_goal_revision = 0;
    cfg_valid = 0;
    cfg_capacity = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    test_field_extremes();
    test_wake_kinds();
    test_full_queue();
    test_capacity_limits();
    test_random_mix();
    drain_wait();
    finished = 1;
    if (errors == 0 && pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

FILE: files.f
rtl/cbtq_pkg.sv
rtl/cbtq_cell.sv
rtl/coalescing_blocked_task_queue_core.sv
tb/sv/tb.sv
